@@ rtl/core/heightmap_vertex_normal_unit_macros.svh @@
// Assertion macros for the heightmap vertex normal unit.
// Included by the checker; depends on nothing else.
`ifndef HEIGHTMAP_VERTEX_NORMAL_UNIT_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMAL_UNIT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define HVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define HVN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

@@ rtl/core/hvn_pkg.sv @@
// Shared types and constants of the heightmap vertex normal unit.
// No dependencies.
package hvn_pkg;

    localparam int CFG_W       = 16;
    localparam int PIX_W       = 8;
    localparam int PAIRS       = 8;
    localparam int DIFF_W      = 9;   // neighbor minus center
    localparam int COEF_W      = 10;  // per-pair height combination
    localparam int SPACE_W     = 24;  // spacing times 255
    localparam int SH_W        = 40;
    localparam int SS_W        = 48;
    localparam int CW          = 50;  // signed cross product component
    localparam int MAG_W       = 49;
    localparam int POS_W       = 6;
    localparam int NORM_MSB    = 28;
    localparam int M_W         = 29;
    localparam int SQ_W        = 58;
    localparam int N_W         = 62;
    localparam int R_W         = 31;
    localparam int SQRT_STAGES = 31;
    localparam int UNIT_SHIFT  = 14;
    localparam int DIV_W       = 46;
    localparam int Q_W         = 15;
    localparam int OUT_W       = 16;
    localparam int SUM_W       = 19;

    localparam logic REG_GRID_SPACING = 1'b0;
    localparam logic REG_ELEV_SCALE   = 1'b1;

    localparam logic [CFG_W-1:0] GRID_SPACING_RESET = 16'd256;
    localparam logic [CFG_W-1:0] ELEV_SCALE_RESET   = 16'd256;

    typedef struct packed {
        logic [PIX_W-1:0] center_height;
        logic [PIX_W-1:0] left_height;
        logic [PIX_W-1:0] right_height;
        logic [PIX_W-1:0] top_height;
        logic [PIX_W-1:0] bottom_height;
        logic [PIX_W-1:0] top_left_height;
        logic [PIX_W-1:0] top_right_height;
        logic [PIX_W-1:0] bottom_left_height;
        logic [PIX_W-1:0] bottom_right_height;
        logic [3:0]       edge_mask;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
    } result_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } unit_t;

    typedef struct packed {
        logic [M_W-1:0] mx;
        logic [M_W-1:0] my;
        logic [M_W-1:0] mz;
        logic [2:0]     neg;
        logic           zero;
    } side_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } lane_t;

endpackage

@@ rtl/core/hvn_cross.sv @@
// Front end: height differences, pair masks and the eight cross products.
// Three register stages; depends on hvn_pkg.
module hvn_cross (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   valid_in,
    input  hvn_pkg::item_t                         item,
    input  logic [hvn_pkg::CFG_W-1:0]              grid_spacing,
    input  logic [hvn_pkg::CFG_W-1:0]              elev_scale,
    output logic                                   valid_out,
    output hvn_pkg::vec_t [hvn_pkg::PAIRS-1:0]     cross_vec
);

    // neighbor walk: L, BL, B, BR, R, TR, T, TL
    localparam int DR [hvn_pkg::PAIRS] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int DC [hvn_pkg::PAIRS] = '{-1, -1, 0, 1, 1, 1, 0, -1};

    function automatic logic signed [hvn_pkg::COEF_W-1:0] term(
        input int coef,
        input logic signed [hvn_pkg::DIFF_W-1:0] e
    );
        logic signed [hvn_pkg::COEF_W-1:0] ee;
        ee = hvn_pkg::COEF_W'(e);
        if (coef == 1)
            return ee;
        else if (coef == -1)
            return -ee;
        else
            return '0;
    endfunction

    logic [hvn_pkg::PIX_W-1:0] nb [hvn_pkg::PAIRS];
    logic [hvn_pkg::PAIRS-1:0] pres;
    logic [hvn_pkg::PAIRS-1:0] en_next;
    logic signed [hvn_pkg::DIFF_W-1:0] e_next [hvn_pkg::PAIRS];
    logic [hvn_pkg::SPACE_W-1:0] s_next;

    logic                              valid1_reg;
    logic signed [hvn_pkg::DIFF_W-1:0] e_reg [hvn_pkg::PAIRS];
    logic [hvn_pkg::PAIRS-1:0]         en1_reg;
    logic [hvn_pkg::SPACE_W-1:0]       s_reg;
    logic [hvn_pkg::CFG_W-1:0]         h_reg;

    logic [hvn_pkg::SH_W-1:0]          sh_next;
    logic [hvn_pkg::SS_W-1:0]          ss_next;
    logic signed [hvn_pkg::COEF_W-1:0] a_next [hvn_pkg::PAIRS];
    logic signed [hvn_pkg::COEF_W-1:0] b_next [hvn_pkg::PAIRS];

    logic                              valid2_reg;
    logic [hvn_pkg::SH_W-1:0]          sh_reg;
    logic [hvn_pkg::SS_W-1:0]          ss_reg;
    logic signed [hvn_pkg::COEF_W-1:0] a_reg [hvn_pkg::PAIRS];
    logic signed [hvn_pkg::COEF_W-1:0] b_reg [hvn_pkg::PAIRS];
    logic [hvn_pkg::PAIRS-1:0]         en2_reg;

    hvn_pkg::vec_t [hvn_pkg::PAIRS-1:0] cross_next;
    hvn_pkg::vec_t [hvn_pkg::PAIRS-1:0] cross_reg;
    logic                               valid3_reg;

    logic signed [hvn_pkg::CW-1:0] sh_ext;
    logic signed [hvn_pkg::CW-1:0] ss_ext;

    // stage 1: differences and masks
    always_comb
    begin
        nb[0] = item.left_height;
        nb[1] = item.bottom_left_height;
        nb[2] = item.bottom_height;
        nb[3] = item.bottom_right_height;
        nb[4] = item.right_height;
        nb[5] = item.top_right_height;
        nb[6] = item.top_height;
        nb[7] = item.top_left_height;
        pres[0] = item.edge_mask[0];
        pres[1] = item.edge_mask[0] & item.edge_mask[3];
        pres[2] = item.edge_mask[3];
        pres[3] = item.edge_mask[1] & item.edge_mask[3];
        pres[4] = item.edge_mask[1];
        pres[5] = item.edge_mask[1] & item.edge_mask[2];
        pres[6] = item.edge_mask[2];
        pres[7] = item.edge_mask[0] & item.edge_mask[2];
        for (int k = 0; k < hvn_pkg::PAIRS; k++)
        begin
            en_next[k] = pres[k] & pres[(k + 1) % hvn_pkg::PAIRS];
            e_next[k]  = $signed({1'b0, nb[k]}) - $signed({1'b0, item.center_height});
        end
        s_next = {grid_spacing, 8'b0} - hvn_pkg::SPACE_W'(grid_spacing);
    end

    // stage 2: shared products and per-pair combinations
    always_comb
    begin
        sh_next = hvn_pkg::SH_W'(s_reg) * hvn_pkg::SH_W'(h_reg);
        ss_next = hvn_pkg::SS_W'(s_reg) * hvn_pkg::SS_W'(s_reg);
        for (int k = 0; k < hvn_pkg::PAIRS; k++)
        begin
            a_next[k] = term(DR[(k + 1) % hvn_pkg::PAIRS], e_reg[k])
                      - term(DR[k], e_reg[(k + 1) % hvn_pkg::PAIRS]);
            b_next[k] = term(DC[(k + 1) % hvn_pkg::PAIRS], e_reg[k])
                      - term(DC[k], e_reg[(k + 1) % hvn_pkg::PAIRS]);
        end
    end

    // stage 3: cross = (sh*a, sh*b, s*s), zero for a missing pair
    always_comb
    begin
        sh_ext = $signed({{(hvn_pkg::CW - hvn_pkg::SH_W){1'b0}}, sh_reg});
        ss_ext = $signed({{(hvn_pkg::CW - hvn_pkg::SS_W){1'b0}}, ss_reg});
        for (int k = 0; k < hvn_pkg::PAIRS; k++)
        begin
            if (en2_reg[k])
            begin
                cross_next[k].x = sh_ext * hvn_pkg::CW'(a_reg[k]);
                cross_next[k].y = sh_ext * hvn_pkg::CW'(b_reg[k]);
                cross_next[k].z = ss_ext;
            end
            else
            begin
                cross_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg     <= e_next;
            en1_reg   <= en_next;
            s_reg     <= s_next;
            h_reg     <= elev_scale;
            sh_reg    <= sh_next;
            ss_reg    <= ss_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            en2_reg   <= en1_reg;
            cross_reg <= cross_next;
        end
    end

    assign valid_out = valid3_reg;
    assign cross_vec = cross_reg;

endmodule

@@ rtl/core/hvn_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on hvn_pkg.
module hvn_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      valid_in,
    input  logic [hvn_pkg::N_W-1:0]   n,
    input  hvn_pkg::side_t            side_in,
    output logic                      valid_out,
    output logic [hvn_pkg::R_W-1:0]   root,
    output hvn_pkg::side_t            side_out
);

    logic [hvn_pkg::N_W-1:0] n_stage   [hvn_pkg::SQRT_STAGES+1];
    logic [hvn_pkg::N_W-1:0] res_stage [hvn_pkg::SQRT_STAGES+1];
    hvn_pkg::side_t          side_stage[hvn_pkg::SQRT_STAGES+1];
    logic                    valid_stage[hvn_pkg::SQRT_STAGES+1];

    logic [hvn_pkg::N_W-1:0] n_reg     [1:hvn_pkg::SQRT_STAGES];
    logic [hvn_pkg::N_W-1:0] res_reg   [1:hvn_pkg::SQRT_STAGES];
    hvn_pkg::side_t          side_reg  [1:hvn_pkg::SQRT_STAGES];
    logic                    valid_reg [1:hvn_pkg::SQRT_STAGES];

    assign n_stage[0]     = n;
    assign res_stage[0]   = '0;
    assign side_stage[0]  = side_in;
    assign valid_stage[0] = valid_in;

    genvar i;
    generate
        for (i = 0; i < hvn_pkg::SQRT_STAGES; i++)
        begin : g_stage
            localparam logic [hvn_pkg::N_W-1:0] STEP =
                hvn_pkg::N_W'(1) << (2 * (hvn_pkg::SQRT_STAGES - 1 - i));
            logic [hvn_pkg::N_W-1:0] trial;
            logic [hvn_pkg::N_W-1:0] n_next;
            logic [hvn_pkg::N_W-1:0] res_next;

            always_comb
            begin
                trial = res_stage[i] + STEP;
                if (n_stage[i] >= trial)
                begin
                    n_next   = n_stage[i] - trial;
                    res_next = (res_stage[i] >> 1) + STEP;
                end
                else
                begin
                    n_next   = n_stage[i];
                    res_next = res_stage[i] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i+1] <= 1'b0;
                else if (adv)
                    valid_reg[i+1] <= valid_stage[i];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    n_reg[i+1]    <= n_next;
                    res_reg[i+1]  <= res_next;
                    side_reg[i+1] <= side_stage[i];
                end
            end

            assign n_stage[i+1]     = n_reg[i+1];
            assign res_stage[i+1]   = res_reg[i+1];
            assign side_stage[i+1]  = side_reg[i+1];
            assign valid_stage[i+1] = valid_reg[i+1];
        end
    endgenerate

    assign valid_out = valid_stage[hvn_pkg::SQRT_STAGES];
    assign root      = res_stage[hvn_pkg::SQRT_STAGES][hvn_pkg::R_W-1:0];
    assign side_out  = side_stage[hvn_pkg::SQRT_STAGES];

endmodule

@@ rtl/core/hvn_divide.sv @@
// Pipelined rounded quotient (m * 2^14 + root/2) / root, one bit per stage.
// Depends on hvn_pkg.
module hvn_divide (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      valid_in,
    input  logic [hvn_pkg::M_W-1:0]   m,
    input  logic [hvn_pkg::R_W-1:0]   root,
    input  hvn_pkg::lane_t            flags_in,
    output logic                      valid_out,
    output logic [hvn_pkg::Q_W-1:0]   quot,
    output hvn_pkg::lane_t            flags_out
);

    logic [hvn_pkg::DIV_W-1:0] rem_reg   [hvn_pkg::Q_W+1];
    logic [hvn_pkg::R_W-1:0]   r_reg     [hvn_pkg::Q_W+1];
    logic [hvn_pkg::Q_W-1:0]   q_reg     [hvn_pkg::Q_W+1];
    hvn_pkg::lane_t            flags_reg [hvn_pkg::Q_W+1];
    logic                      valid_reg [hvn_pkg::Q_W+1];

    logic [hvn_pkg::DIV_W-1:0] num_next;

    assign num_next = hvn_pkg::DIV_W'({m, {hvn_pkg::UNIT_SHIFT{1'b0}}})
                    + hvn_pkg::DIV_W'(root >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (adv)
            valid_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]   <= num_next;
            r_reg[0]     <= root;
            q_reg[0]     <= '0;
            flags_reg[0] <= flags_in;
        end
    end

    genvar i;
    generate
        for (i = 0; i < hvn_pkg::Q_W; i++)
        begin : g_stage
            localparam int SH = hvn_pkg::Q_W - 1 - i;
            logic [hvn_pkg::DIV_W-1:0] trial;
            logic [hvn_pkg::DIV_W-1:0] rem_next;
            logic [hvn_pkg::Q_W-1:0]   q_next;

            always_comb
            begin
                trial = hvn_pkg::DIV_W'(r_reg[i]) << SH;
                if (rem_reg[i] >= trial)
                begin
                    rem_next = rem_reg[i] - trial;
                    q_next   = q_reg[i] | (hvn_pkg::Q_W'(1) << SH);
                end
                else
                begin
                    rem_next = rem_reg[i];
                    q_next   = q_reg[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i+1] <= 1'b0;
                else if (adv)
                    valid_reg[i+1] <= valid_reg[i];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i+1]   <= rem_next;
                    r_reg[i+1]     <= r_reg[i];
                    q_reg[i+1]     <= q_next;
                    flags_reg[i+1] <= flags_reg[i];
                end
            end
        end
    endgenerate

    assign valid_out = valid_reg[hvn_pkg::Q_W];
    assign quot      = q_reg[hvn_pkg::Q_W];
    assign flags_out = flags_reg[hvn_pkg::Q_W];

endmodule

@@ rtl/core/hvn_unitise.sv @@
// Vector normalizer: align magnitudes, sum of squares, square root, divide.
// Uses hvn_isqrt and hvn_divide; depends on hvn_pkg.
module hvn_unitise (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           valid_in,
    input  hvn_pkg::vec_t  vec,
    output logic           valid_out,
    output hvn_pkg::unit_t norm
);

    logic signed [hvn_pkg::CW-1:0] comp [3];
    logic [hvn_pkg::MAG_W-1:0]     mag_next [3];
    logic [2:0]                    neg_next;

    logic                      valid1_reg;
    logic [hvn_pkg::MAG_W-1:0] mag1_reg [3];
    logic [2:0]                neg1_reg;
    logic [hvn_pkg::MAG_W-1:0] orm_reg;

    logic [hvn_pkg::POS_W-1:0] pos_next;
    logic                      valid2_reg;
    logic [hvn_pkg::MAG_W-1:0] mag2_reg [3];
    logic [2:0]                neg2_reg;
    logic [hvn_pkg::POS_W-1:0] pos_reg;
    logic                      zero2_reg;

    logic [hvn_pkg::M_W-1:0]   m_next [3];
    hvn_pkg::side_t            side3_next;
    logic                      valid3_reg;
    hvn_pkg::side_t            side3_reg;

    logic [hvn_pkg::SQ_W-1:0]  sq_next [3];
    logic                      valid4_reg;
    logic [hvn_pkg::SQ_W-1:0]  sq_reg [3];
    hvn_pkg::side_t            side4_reg;

    logic                      valid5_reg;
    logic [hvn_pkg::N_W-1:0]   n_reg;
    hvn_pkg::side_t            side5_reg;

    logic                      sq_valid;
    logic [hvn_pkg::R_W-1:0]   root;
    hvn_pkg::side_t            side_s;

    logic [hvn_pkg::M_W-1:0]   lane_m [3];
    logic [2:0]                dvalid;
    logic [hvn_pkg::Q_W-1:0]   quot [3];
    hvn_pkg::lane_t            flags [3];

    logic signed [hvn_pkg::OUT_W-1:0] val_next [3];
    logic                             valid_out_reg;
    hvn_pkg::unit_t                   norm_reg;

    assign comp[0] = vec.x;
    assign comp[1] = vec.y;
    assign comp[2] = vec.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = comp[i][hvn_pkg::CW-1];
            mag_next[i] = hvn_pkg::MAG_W'(neg_next[i] ? -comp[i] : comp[i]);
        end
    end

    // leading one of the OR of all magnitudes
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < hvn_pkg::MAG_W; i++)
        begin
            if (orm_reg[i])
                pos_next = hvn_pkg::POS_W'(i);
        end
    end

    // bring the largest magnitude into [2^28, 2^29)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos_reg >= hvn_pkg::POS_W'(hvn_pkg::NORM_MSB))
                m_next[i] = hvn_pkg::M_W'(mag2_reg[i] >>
                            (pos_reg - hvn_pkg::POS_W'(hvn_pkg::NORM_MSB)));
            else
                m_next[i] = hvn_pkg::M_W'(mag2_reg[i] <<
                            (hvn_pkg::POS_W'(hvn_pkg::NORM_MSB) - pos_reg));
        end
        side3_next.mx   = m_next[0];
        side3_next.my   = m_next[1];
        side3_next.mz   = m_next[2];
        side3_next.neg  = neg2_reg;
        side3_next.zero = zero2_reg;
    end

    assign sq_next[0] = hvn_pkg::SQ_W'(side3_reg.mx) * hvn_pkg::SQ_W'(side3_reg.mx);
    assign sq_next[1] = hvn_pkg::SQ_W'(side3_reg.my) * hvn_pkg::SQ_W'(side3_reg.my);
    assign sq_next[2] = hvn_pkg::SQ_W'(side3_reg.mz) * hvn_pkg::SQ_W'(side3_reg.mz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            valid4_reg    <= 1'b0;
            valid5_reg    <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg    <= valid_in;
            valid2_reg    <= valid1_reg;
            valid3_reg    <= valid2_reg;
            valid4_reg    <= valid3_reg;
            valid5_reg    <= valid4_reg;
            valid_out_reg <= &dvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg  <= mag_next;
            neg1_reg  <= neg_next;
            orm_reg   <= mag_next[0] | mag_next[1] | mag_next[2];
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            pos_reg   <= pos_next;
            zero2_reg <= (orm_reg == '0);
            side3_reg <= side3_next;
            sq_reg    <= sq_next;
            side4_reg <= side3_reg;
            n_reg     <= hvn_pkg::N_W'(sq_reg[0]) + hvn_pkg::N_W'(sq_reg[1])
                       + hvn_pkg::N_W'(sq_reg[2]);
            side5_reg <= side4_reg;
            norm_reg.x <= val_next[0];
            norm_reg.y <= val_next[1];
            norm_reg.z <= val_next[2];
        end
    end

    hvn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (valid5_reg),
        .n         (n_reg),
        .side_in   (side5_reg),
        .valid_out (sq_valid),
        .root      (root),
        .side_out  (side_s)
    );

    assign lane_m[0] = side_s.mx;
    assign lane_m[1] = side_s.my;
    assign lane_m[2] = side_s.mz;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            hvn_pkg::lane_t lane_in;
            assign lane_in.neg  = side_s.neg[g];
            assign lane_in.zero = side_s.zero;

            hvn_divide u_divide (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (sq_valid),
                .m         (lane_m[g]),
                .root      (root),
                .flags_in  (lane_in),
                .valid_out (dvalid[g]),
                .quot      (quot[g]),
                .flags_out (flags[g])
            );

            always_comb
            begin
                if (flags[g].zero)
                    val_next[g] = '0;
                else if (flags[g].neg)
                    val_next[g] = -hvn_pkg::OUT_W'(quot[g]);
                else
                    val_next[g] = hvn_pkg::OUT_W'(quot[g]);
            end
        end
    endgenerate

    assign valid_out = valid_out_reg;
    assign norm      = norm_reg;

endmodule

@@ rtl/core/heightmap_vertex_normal_unit.sv @@
// Top level of the heightmap vertex normal unit.
// Uses hvn_cross and hvn_unitise; depends on hvn_pkg.

// Takes one 3x3 height window per clock and returns the unit normal of the
// center vertex in signed Q2.14, one result per window, in order. Throughput
// is one transaction per cycle unless a waiting result stalls it. There are two
// normalizers in series (eight in parallel for the neighbor pairs, one for
// the sum), each with a 31-stage bit-per-stage square root and a 16-stage
// restoring divider. The whole pipeline holds when a result waits and
// result_ready is low. Configuration registers are to be written only when
// the block is empty (not enforced) and take effect for the next window.
module heightmap_vertex_normal_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_index,
    input  logic [hvn_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  hvn_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output hvn_pkg::result_t              result
);

    logic [hvn_pkg::CFG_W-1:0] grid_spacing_reg;
    logic [hvn_pkg::CFG_W-1:0] elev_scale_reg;

    logic                               adv;
    logic                               cross_valid;
    hvn_pkg::vec_t [hvn_pkg::PAIRS-1:0] cross_vec;
    logic [hvn_pkg::PAIRS-1:0]          pair_valid;
    hvn_pkg::unit_t                     pair_norm [hvn_pkg::PAIRS];

    logic signed [hvn_pkg::SUM_W-1:0] acc_x;
    logic signed [hvn_pkg::SUM_W-1:0] acc_y;
    logic signed [hvn_pkg::SUM_W-1:0] acc_z;
    hvn_pkg::vec_t                    sum_next;
    hvn_pkg::vec_t                    sum_reg;
    logic                             sum_valid_reg;

    logic           final_valid;
    hvn_pkg::unit_t final_norm;

    assign adv        = result_ready | ~final_valid;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_spacing_reg <= hvn_pkg::GRID_SPACING_RESET;
            elev_scale_reg   <= hvn_pkg::ELEV_SCALE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                hvn_pkg::REG_GRID_SPACING: grid_spacing_reg <= cfg_data;
                hvn_pkg::REG_ELEV_SCALE:   elev_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    hvn_cross u_cross (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .valid_in     (item_valid),
        .item         (item),
        .grid_spacing (grid_spacing_reg),
        .elev_scale   (elev_scale_reg),
        .valid_out    (cross_valid),
        .cross_vec    (cross_vec)
    );

    genvar k;
    generate
        for (k = 0; k < hvn_pkg::PAIRS; k++)
        begin : g_pair
            hvn_unitise u_pair (
                .clk       (clk),
                .rst_n     (rst_n),
                .adv       (adv),
                .valid_in  (cross_valid),
                .vec       (cross_vec[k]),
                .valid_out (pair_valid[k]),
                .norm      (pair_norm[k])
            );
        end
    endgenerate

    always_comb
    begin
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        for (int i = 0; i < hvn_pkg::PAIRS; i++)
        begin
            acc_x = acc_x + hvn_pkg::SUM_W'(pair_norm[i].x);
            acc_y = acc_y + hvn_pkg::SUM_W'(pair_norm[i].y);
            acc_z = acc_z + hvn_pkg::SUM_W'(pair_norm[i].z);
        end
        sum_next.x = hvn_pkg::CW'(acc_x);
        sum_next.y = hvn_pkg::CW'(acc_y);
        sum_next.z = hvn_pkg::CW'(acc_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (adv)
            sum_valid_reg <= &pair_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sum_reg <= sum_next;
    end

    hvn_unitise u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (sum_valid_reg),
        .vec       (sum_reg),
        .valid_out (final_valid),
        .norm      (final_norm)
    );

    assign result_valid    = final_valid;
    assign result.normal_x = final_norm.x;
    assign result.normal_y = final_norm.y;
    assign result.normal_z = final_norm.z;

endmodule

@@ rtl/core/hvn_checker.sv @@
// Port-level checks for the heightmap vertex normal unit, bound to the top.
// Depends on hvn_pkg and the macro header.
`include "heightmap_vertex_normal_unit_macros.svh"

module hvn_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input hvn_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input hvn_pkg::result_t result
);

    logic item_seen;
    assign item_seen = item_valid | (item != item);

    // a held result stays put
    `HVN_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result))

    // an output stall stops intake
    `HVN_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, result_valid && !result_ready, !item_ready)

    // every component is a unit-range Q2.14 value
    `HVN_ASSERT_NOW(a_unit_range, clk, rst_n, result_valid, (result.normal_x >= -16'sd16384) && (result.normal_x <= 16'sd16384) && (result.normal_y >= -16'sd16384) && (result.normal_y <= 16'sd16384) && (result.normal_z >= -16'sd16384) && (result.normal_z <= 16'sd16384))

    // with no result waiting the block takes a transaction
    `HVN_ASSERT_NOW(a_ready_when_empty, clk, rst_n, item_seen && !result_valid, item_ready)

endmodule

bind heightmap_vertex_normal_unit hvn_checker u_hvn_checker (.*);
